[src/fed_pkg.sv]
// Shared constants, types and fixed-point helpers for the feedback echo delay unit.
// No dependencies; imported by the top level.
package fed_pkg;

    localparam int LINE_DEPTH  = 16384;
    localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
    localparam int SAMPLE_BITS = 16;
    localparam int Q_SHIFT     = 15;
    localparam int COEF_BITS   = Q_SHIFT + 2;
    localparam int DELAY_BITS  = 14;
    localparam int GAIN_BITS   = 16;
    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;
    localparam int ACC_BITS    = SAMPLE_BITS + COEF_BITS + 1;

    localparam logic [COEF_BITS-1:0] Q_ONE = COEF_BITS'(1) << Q_SHIFT;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET   = DELAY_BITS'(8192);
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET    = GAIN_BITS'(16384);
    localparam logic [GAIN_BITS-1:0]  WET_RESET     = GAIN_BITS'(16384);
    localparam logic [GAIN_BITS-1:0]  LOWPASS_RESET = GAIN_BITS'(19661);

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (Q_SHIFT - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        ACC_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [ADDR_BITS-1:0]          line_addr_t;

    typedef enum logic [1:0] {
        REG_DELAY,
        REG_GAIN,
        REG_WET,
        REG_LOWPASS
    } reg_idx_t;

    // Add half an LSB, then floor-shift by the Q15 scale.
    function automatic acc_t round_q15(input acc_t v);
        acc_t t;
        t = v + ROUND_HALF;
        return t >>> Q_SHIFT;
    endfunction

    // Clamp to the sample range.
    function automatic sample_t sat_sample(input acc_t v);
        acc_t t;
        if (v > SAT_HI)
        begin
            t = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            t = SAT_LO;
        end
        else
        begin
            t = v;
        end
        return SAMPLE_BITS'(t);
    endfunction

    // Clamp a Q1.15 gain register to 1.0.
    function automatic logic [COEF_BITS-1:0] clamp_one(input logic [GAIN_BITS-1:0] g);
        logic [COEF_BITS-1:0] t;
        t = COEF_BITS'(g);
        if (t > Q_ONE)
        begin
            t = Q_ONE;
        end
        return t;
    endfunction

endpackage

[src/fed_line_ram.sv]
// Single-port-write, single-port-read synchronous RAM for the echo line.
// Read data is registered. No package dependency.
module fed_line_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/feedback_echo_delay_unit.sv]
// Feedback echo with a one-pole low-pass in the loop, Q1.15 samples.
// Depends on fed_pkg and fed_line_ram (echo line storage).
//
// Usage:
//   Input channel (in_valid/in_ready, sample_in) takes one dry sample per
//   item; output channel (out_valid/out_ready, sample_out) returns one mixed
//   sample per item, in order.
//   An item runs through a seven-state sequencer around the line RAM:
//   read issue, filter products, filter round, feedback product, loop sum
//   and line write, mix products, mix round. The result is loaded into the
//   output register as the sequencer leaves the mix round, and a new item
//   is taken only once the sequencer is back in its idle state; the
//   sequential multiply chain of the loop sets that pace.
//   A finished result waits in the output register while the next item is
//   taken; if the receiver still holds off when the next result is ready,
//   the sequencer holds in its last state and in_ready stays low.
//   Reset clears the write position, filter memory and registers (delay 8192,
//   feedback 0.5, wet 0.5, pole 0.6). The line RAM is not cleared: line entries
//   not yet written since reset read as zero, tracked by the write position
//   and a wrap flag, so no clearing pass is needed.
//   Registers (APB, byte address 4*i): delay, feedback, wet mix, pole.
//   Write them only while the block is idle.
module feedback_echo_delay_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fed_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [fed_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [fed_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [fed_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fed_pkg::SAMPLE_BITS-1:0] sample_out
);

    import fed_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULF,
        S_FILT,
        S_MULG,
        S_SUM,
        S_MULW,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [DELAY_BITS-1:0] delay_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [GAIN_BITS-1:0]  wet_reg;
    logic [GAIN_BITS-1:0]  lowpass_reg;

    line_addr_t wr_idx_reg;
    logic       wrapped_reg;
    sample_t    filt_mem_reg;
    logic       rd_ok_reg;

    sample_t x_reg;
    acc_t    p_line_reg;
    acc_t    p_mem_reg;
    acc_t    p_fb_reg;
    sample_t y_reg;
    acc_t    p_wet_reg;
    acc_t    p_dry_reg;

    logic    out_valid_reg, out_valid_next;
    sample_t sample_out_reg, sample_out_next;

    logic       cfg_wr;
    reg_idx_t   cfg_idx;
    logic       accept;
    line_addr_t rd_addr;
    logic       rd_ok_next;
    sample_t    rd_data;
    sample_t    line_s;
    logic       mem_we;

    logic [COEF_BITS-1:0] coef_a;
    logic [COEF_BITS-1:0] wet_c;
    logic signed [COEF_BITS:0] a_s;
    logic signed [COEF_BITS:0] one_minus_a_s;
    logic signed [COEF_BITS:0] gain_s;
    logic signed [COEF_BITS:0] wet_s;
    logic signed [COEF_BITS:0] dry_s;

    sample_t f_next;
    sample_t y_next;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_DELAY:   prdata = PDATA_BITS'(delay_reg);
            REG_GAIN:    prdata = PDATA_BITS'(gain_reg);
            REG_WET:     prdata = PDATA_BITS'(wet_reg);
            REG_LOWPASS: prdata = PDATA_BITS'(lowpass_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= DELAY_RESET;
            gain_reg    <= GAIN_RESET;
            wet_reg     <= WET_RESET;
            lowpass_reg <= LOWPASS_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DELAY:   delay_reg   <= pwdata[DELAY_BITS-1:0];
                REG_GAIN:    gain_reg    <= pwdata[GAIN_BITS-1:0];
                REG_WET:     wet_reg     <= pwdata[GAIN_BITS-1:0];
                REG_LOWPASS: lowpass_reg <= pwdata[GAIN_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // Line RAM
    assign accept  = in_valid && in_ready;
    assign rd_addr = wr_idx_reg - ADDR_BITS'(delay_reg);
    // An entry holds written data once the write position has passed it.
    assign rd_ok_next = wrapped_reg || (rd_addr < wr_idx_reg);
    assign mem_we  = (state_reg == S_SUM);

    fed_line_ram #(
        .DEPTH(LINE_DEPTH),
        .WIDTH(SAMPLE_BITS)
    ) u_line (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_idx_reg),
        .wdata (y_next),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Datapath
    assign coef_a        = clamp_one(lowpass_reg);
    assign wet_c         = clamp_one(wet_reg);
    assign a_s           = signed'({1'b0, coef_a});
    assign one_minus_a_s = signed'({1'b0, Q_ONE - coef_a});
    assign gain_s        = signed'({1'b0, COEF_BITS'(gain_reg)});
    assign wet_s         = signed'({1'b0, wet_c});
    assign dry_s         = signed'({1'b0, Q_ONE - wet_c});
    assign line_s        = rd_ok_reg ? rd_data : '0;

    assign f_next = sat_sample(round_q15(p_line_reg + p_mem_reg));
    assign y_next = sat_sample(ACC_BITS'(x_reg) + round_q15(p_fb_reg));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= sample_in;
            rd_ok_reg <= rd_ok_next;
        end
        if (state_reg == S_MULF)
        begin
            p_line_reg <= one_minus_a_s * line_s;
            p_mem_reg  <= a_s * filt_mem_reg;
        end
        if (state_reg == S_MULG)
        begin
            p_fb_reg <= gain_s * filt_mem_reg;
        end
        if (state_reg == S_SUM)
        begin
            y_reg <= y_next;
        end
        if (state_reg == S_MULW)
        begin
            p_wet_reg <= wet_s * y_reg;
            p_dry_reg <= dry_s * x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            wrapped_reg  <= 1'b0;
            filt_mem_reg <= '0;
        end
        else
        begin
            if (state_reg == S_FILT)
            begin
                filt_mem_reg <= f_next;
            end
            if (mem_we)
            begin
                wr_idx_reg <= wr_idx_reg + 1'b1;
                if (wr_idx_reg == '1)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    // Sequencer and output register
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MULF;
                end
            end
            S_MULF: state_next = S_FILT;
            S_FILT: state_next = S_MULG;
            S_MULG: state_next = S_SUM;
            S_SUM:  state_next = S_MULW;
            S_MULW: state_next = S_OUT;
            S_OUT:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = sat_sample(round_q15(p_wet_reg + p_dry_reg));
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            sample_out_reg <= sample_out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

`ifndef SYNTH
    a_write_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 mem_we)
        else $error("line write not four cycles after item");

    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (wr_idx_reg == $past(wr_idx_reg) + 1'b1))
        else $error("write position did not advance");

    a_filter_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FILT) |=> $stable(filt_mem_reg))
        else $error("filter memory changed outside filter step");

    a_wrap_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wrapped_reg) |-> (wr_idx_reg == '0))
        else $error("wrap flag set away from line start");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside final step");
`endif

endmodule

[dv/tb.sv]
// Testbench for feedback_echo_delay_unit: directed table, random settings, extreme delays.
// Depends on fed_pkg and RTL; expected samples: in-file echo predictor or pinned rows.
module tb;
    import fed_pkg::*;

    localparam int      WATCHDOG_LIMIT = 1000;
    localparam int      DRAIN_CYCLES   = 20;
    localparam int      RANDOM_BLOCKS  = 9;
    localparam int      BLOCK_ITEMS    = 100;
    localparam int      TAIL_ITEMS     = 64;
    localparam int      DIR_ROWS       = 22;
    localparam longint UNITY          = 32768;

    typedef struct packed {
        logic [1:0] cfg_id;   // 0 keeps the current settings
        sample_t    x;
        logic       pinned;   // want is known without the predictor
        sample_t    want;
    } dir_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_BITS-1:0] paddr    = '0;
    logic [PDATA_BITS-1:0] pwdata   = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    sample_t               sample_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sample_t               sample_out;

    logic    pin_en  = 1'b0;
    sample_t pin_val = '0;
    bit      in_idle  = 1'b1;
    bit      out_idle = 1'b1;
    int      hold_left = 0;

    // predictor state and its copy of the registers
    sample_t         echo_line [LINE_DEPTH];
    int              line_wr_pos = 0;
    sample_t         lp_state = '0;
    logic [13:0]     cfg_delay = 14'd8192;
    logic [15:0]     cfg_gain  = 16'd16384;
    logic [15:0]     cfg_wet   = 16'd16384;
    logic [15:0]     cfg_pole  = 16'd19661;

    sample_t mix_expected [$];
    sample_t predicted;
    int      fail_count   = 0;
    int      items_sent   = 0;
    int      results_seen = 0;
    int      reg_writes   = 0;
    int      quiet_cycles = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // reset settings: line reads zero, so the mix returns the dry sample
        '{2'd0, 16'h0000, 1'b1, 16'h0000},
        '{2'd0, 16'h7FFF, 1'b1, 16'h7FFF},
        '{2'd0, 16'h8000, 1'b1, 16'h8000},
        '{2'd0, 16'h0001, 1'b1, 16'h0001},
        '{2'd0, 16'hFFFF, 1'b1, 16'hFFFF},
        '{2'd0, 16'h5555, 1'b1, 16'h5555},
        '{2'd0, 16'hAAAA, 1'b1, 16'hAAAA},
        // delay 1, gain near 2.0, fully wet, no filtering: saturating loop
        '{2'd1, 16'h7FFF, 1'b0, 16'h0000},
        '{2'd0, 16'h7FFF, 1'b0, 16'h0000},
        '{2'd0, 16'h8000, 1'b0, 16'h0000},
        '{2'd0, 16'h8000, 1'b0, 16'h0000},
        '{2'd0, 16'h0000, 1'b0, 16'h0000},
        '{2'd0, 16'h0000, 1'b0, 16'h0000},
        '{2'd0, 16'h0064, 1'b0, 16'h0000},
        // zero delay, no feedback, wet and pole above one: output is the input
        '{2'd2, 16'h3039, 1'b1, 16'h3039},
        '{2'd0, 16'h8000, 1'b1, 16'h8000},
        '{2'd0, 16'h7FFF, 1'b1, 16'h7FFF},
        // pole above one holds the filter memory while feedback is on
        '{2'd3, 16'h1000, 1'b0, 16'h0000},
        '{2'd0, 16'hF000, 1'b0, 16'h0000},
        '{2'd0, 16'h7FFF, 1'b0, 16'h0000},
        '{2'd0, 16'h8000, 1'b0, 16'h0000},
        '{2'd0, 16'h0000, 1'b0, 16'h0000}
    };

    feedback_echo_delay_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    always #2 clk = ~clk;

    function automatic longint q15_round(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic sample_t clip16(input longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return sample_t'(v);
    endfunction

    // One echo step: read the delayed entry, filter, feed back, write, mix.
    function automatic sample_t echo_predict(input sample_t x);
        int      rd_pos;
        longint  pole;
        longint  wet;
        sample_t filt;
        sample_t loop_val;
        rd_pos   = (line_wr_pos + LINE_DEPTH - int'(cfg_delay) % LINE_DEPTH) % LINE_DEPTH;
        pole     = (longint'(cfg_pole) > UNITY) ? UNITY : longint'(cfg_pole);
        wet      = (longint'(cfg_wet) > UNITY) ? UNITY : longint'(cfg_wet);
        filt     = clip16(q15_round((UNITY - pole) * longint'(echo_line[rd_pos])
                                    + pole * longint'(lp_state)));
        lp_state = filt;
        loop_val = clip16(longint'(x) + q15_round(longint'(cfg_gain) * longint'(filt)));
        echo_line[line_wr_pos] = loop_val;
        line_wr_pos = (line_wr_pos + 1) % LINE_DEPTH;
        return clip16(q15_round(wet * longint'(loop_val) + (UNITY - wet) * longint'(x)));
    endfunction

    function automatic logic [31:0] reg_mask(input reg_idx_t idx);
        return (idx == REG_DELAY) ? 32'h0000_3FFF : 32'h0000_FFFF;
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return sample_t'($urandom_range(0, 512) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Write a register, then read it back.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        logic [31:0] kept;
        kept = data & reg_mask(idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'(int'(idx) * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DELAY:   cfg_delay = kept[13:0];
            REG_GAIN:    cfg_gain  = kept[15:0];
            REG_WET:     cfg_wet   = kept[15:0];
            REG_LOWPASS: cfg_pole  = kept[15:0];
            default:     ;
        endcase
        reg_writes++;
        @(posedge clk);
        psel    <= 1'b1;
        paddr   <= PADDR_BITS'(int'(idx) * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== kept)
        begin
            $error("%s readback: expected %0h, got %0h", idx.name(), kept, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid and wait until every result is back and the sequencer is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (mix_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic send_sample(input sample_t x, input logic pinned, input sample_t want);
        if (in_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        pin_en    <= pinned;
        pin_val   <= want;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic load_dir_cfg(input logic [1:0] id);
        case (id)
            2'd1:
            begin
                write_reg(REG_DELAY, 32'd1);
                write_reg(REG_GAIN, 32'hFFFF);
                write_reg(REG_WET, 32'h8000);
                write_reg(REG_LOWPASS, 32'd0);
            end
            2'd2:
            begin
                write_reg(REG_DELAY, 32'h4000);    // masks to zero delay
                write_reg(REG_GAIN, 32'd0);
                write_reg(REG_WET, 32'hFFFF);
                write_reg(REG_LOWPASS, 32'hFFFF);
            end
            default:
            begin
                write_reg(REG_DELAY, 32'd2);
                write_reg(REG_GAIN, 32'h8000);
                write_reg(REG_WET, 32'h8000);
                write_reg(REG_LOWPASS, 32'hFFFF);
            end
        endcase
    endtask

    task automatic random_settings();
        int dly;
        int gain;
        int wet;
        int pole;
        case ($urandom_range(0, 9))
            0:       dly = 0;
            1:       dly = 16383;
            2, 3:    dly = $urandom_range(1, 16383);
            default: dly = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 5))
            0:       gain = 0;
            1:       gain = 65535;
            2:       gain = 32768;
            default: gain = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 5))
            0:       wet = 0;
            1:       wet = 32768;
            2:       wet = $urandom_range(32769, 65535);
            default: wet = $urandom_range(0, 32768);
        endcase
        case ($urandom_range(0, 5))
            0:       pole = 0;
            1:       pole = 32768;
            2:       pole = $urandom_range(32769, 65535);
            default: pole = $urandom_range(0, 32768);
        endcase
        // junk in the unused upper bits must be dropped
        write_reg(REG_DELAY, {16'($urandom), 2'($urandom), 14'(dly)});
        write_reg(REG_GAIN, {16'($urandom), 16'(gain)});
        write_reg(REG_WET, {16'($urandom), 16'(wet)});
        write_reg(REG_LOWPASS, {16'($urandom), 16'(pole)});
    endtask

    // Receiver stalls in random bursts.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (out_idle && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            hold_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Predict on each accepted item, check each accepted result.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            predicted = echo_predict(sample_in);
            mix_expected.push_back(pin_en ? pin_val : predicted);
            items_sent++;
        end
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (mix_expected.size() == 0)
            begin
                $error("sample_out: no item pending, got %0d", sample_out);
                fail_count++;
            end
            else
            begin
                predicted = mix_expected.pop_front();
                if (sample_out !== predicted)
                begin
                    $error("sample_out mismatch: expected %0d, got %0d", predicted, sample_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int i;
        int blk;
        for (i = 0; i < LINE_DEPTH; i++)
        begin
            echo_line[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].cfg_id != 2'd0)
            begin
                settle();
                load_dir_cfg(dir_rows[i].cfg_id);
            end
            send_sample(dir_rows[i].x, dir_rows[i].pinned, dir_rows[i].want);
        end

        for (blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            settle();
            random_settings();
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            repeat (BLOCK_ITEMS) send_sample(pick_sample(), 1'b0, '0);
        end

        // No idling at the end: zero delay, then the longest delay.
        settle();
        in_idle  = 1'b0;
        out_idle = 1'b0;
        write_reg(REG_DELAY, 32'd0);
        write_reg(REG_GAIN, 32'd26000);
        write_reg(REG_WET, 32'd20000);
        write_reg(REG_LOWPASS, 32'd8000);
        repeat (TAIL_ITEMS) send_sample(pick_sample(), 1'b0, '0);
        settle();
        write_reg(REG_DELAY, 32'd16383);
        repeat (TAIL_ITEMS) send_sample(pick_sample(), 1'b0, '0);
        in_valid <= 1'b0;

        while (mix_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("directed table, %0d random setting blocks, zero and longest delay back to back",
                 RANDOM_BLOCKS);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
